// ----- rtl/ccr_pkg.sv -----
// shared types, widths and arithmetic helpers for the catmull-rom point evaluator
package ccr_pkg;

  localparam int COORD_W    = 32;
  localparam int POS_W      = 17;
  localparam int POS_BITS   = 16;
  localparam int KNOT_SHIFT = 16;
  localparam int SQ_W       = 32;
  localparam int SQ_STAGES  = 2 * SQ_W;
  localparam int RAD_W      = 2 * SQ_W;
  localparam int KNOT_W     = 25;
  localparam int NODE_W     = 36;
  localparam int NUM_W      = 28;
  localparam int DEN_W      = 27;
  localparam int QB         = 38;
  localparam int DVD_W      = 63;
  localparam int LERP_LAT   = QB + 6;

  localparam logic [POS_W-1:0] POS_ONE = POS_W'(1) << POS_BITS;

  typedef struct packed {
    logic signed [COORD_W-1:0] p0_x;
    logic signed [COORD_W-1:0] p0_y;
    logic signed [COORD_W-1:0] p1_x;
    logic signed [COORD_W-1:0] p1_y;
    logic signed [COORD_W-1:0] p2_x;
    logic signed [COORD_W-1:0] p2_y;
    logic signed [COORD_W-1:0] p3_x;
    logic signed [COORD_W-1:0] p3_y;
    logic [POS_W-1:0]          position_fraction;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] curve_x;
    logic signed [COORD_W-1:0] curve_y;
    logic                      degenerate;
  } out_t;

  typedef struct packed {
    logic [SQ_W+2:0] rem;
    logic [SQ_W-1:0] root;
  } sq_t;

  typedef struct packed {
    logic [RAD_W-1:0] rad;
    logic             big;
    sq_t              st;
  } sq_lane_t;

  typedef struct packed {
    logic degen;
    in_t  pts;
  } side_t;

  typedef struct packed {
    logic               valid;
    logic               degen;
    logic [KNOT_W-1:0]  k01;
    logic [KNOT_W-1:0]  k12;
    logic [KNOT_W-1:0]  k23;
    logic [KNOT_W-1:0]  tmt1;
    logic [KNOT_W:0]    t;
    logic [KNOT_W:0]    t2;
    logic [KNOT_W:0]    t31;
    logic signed [KNOT_W:0] tmt2;
  } ctl_t;

  // one restoring square-root digit
  function automatic sq_t sqrt_step(input sq_t s, input logic [1:0] d);
    logic [SQ_W+2:0] cur;
    logic [SQ_W+2:0] trial;
    sq_t             r;
    cur   = {s.rem[SQ_W:0], d};
    trial = {1'b0, s.root, 2'b01};
    if (cur >= trial) begin
      r.rem  = cur - trial;
      r.root = {s.root[SQ_W-2:0], 1'b1};
    end else begin
      r.rem  = cur;
      r.root = {s.root[SQ_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ----- rtl/ccr_lerp.sv -----
// pipelined rounded interpolation node with bit-serial divide chain
module ccr_lerp (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [ccr_pkg::NODE_W-1:0] a,
  input  logic signed [ccr_pkg::NODE_W-1:0] b,
  input  logic signed [ccr_pkg::NUM_W-1:0]  num,
  input  logic [ccr_pkg::DEN_W-1:0]         den,
  output logic signed [ccr_pkg::NODE_W-1:0] res
);
  import ccr_pkg::*;

  localparam int PROD_W = NODE_W + NUM_W + 1;
  localparam int SUM_W  = QB + 2;
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'((64'sd1 <<< (NODE_W - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_W'(64'sd1 <<< (NODE_W - 1));

  typedef struct packed {
    logic [DEN_W-1:0]         rem;
    logic [QB-1:0]            qd;
    logic                     ovf;
    logic                     neg;
    logic [DEN_W-1:0]         den;
    logic signed [NODE_W-1:0] a;
  } div_t;

  logic signed [NODE_W:0]   diff_r;
  logic signed [NUM_W-1:0]  num_r;
  logic [DEN_W-1:0]         den0_r, den1_r, den2_r;
  logic signed [NODE_W-1:0] a0_r, a1_r, a2_r, a4_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [DVD_W-1:0]         dvd_r;
  logic                     neg2_r;
  div_t                     dv_r [QB+1];
  logic signed [QB:0]       r4_r;
  logic signed [NODE_W-1:0] res_r;

  logic signed [PROD_W-1:0] prod_mag;
  logic [DVD_W-QB-1:0]      hi;
  logic [QB-1:0]            q_fin;
  logic signed [SUM_W-1:0]  sum;

  always_comb begin
    prod_mag = prod_r[PROD_W-1] ? -prod_r : prod_r;
    hi       = dvd_r[DVD_W-1:QB];
    q_fin    = dv_r[QB].ovf ? {QB{1'b1}} : dv_r[QB].qd;
    sum      = SUM_W'(a4_r) + SUM_W'(r4_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff_r    <= (NODE_W+1)'(b) - (NODE_W+1)'(a);
      num_r     <= num;
      den0_r    <= den;
      a0_r      <= a;
      prod_r    <= PROD_W'(diff_r) * PROD_W'(num_r);
      den1_r    <= den0_r;
      a1_r      <= a0_r;
      neg2_r    <= prod_r[PROD_W-1];
      dvd_r     <= prod_mag[DVD_W-1:0] + DVD_W'(den1_r >> 1);
      den2_r    <= den1_r;
      a2_r      <= a1_r;
      dv_r[0].rem <= DEN_W'(hi);
      dv_r[0].qd  <= dvd_r[QB-1:0];
      dv_r[0].ovf <= DEN_W'(hi) >= den2_r;
      dv_r[0].neg <= neg2_r;
      dv_r[0].den <= den2_r;
      dv_r[0].a   <= a2_r;
      r4_r      <= dv_r[QB].neg ? -$signed({1'b0, q_fin}) : $signed({1'b0, q_fin});
      a4_r      <= dv_r[QB].a;
      if (sum > SUM_MAX) begin
        res_r <= SUM_MAX[NODE_W-1:0];
      end else if (sum < SUM_MIN) begin
        res_r <= SUM_MIN[NODE_W-1:0];
      end else begin
        res_r <= sum[NODE_W-1:0];
      end
    end
  end

  for (genvar i = 1; i <= QB; i++) begin : g_div
    logic [DEN_W:0] cur;
    logic [DEN_W:0] sub;
    logic           ge;
    div_t           nxt;
    always_comb begin
      cur = {dv_r[i-1].rem, dv_r[i-1].qd[QB-1]};
      sub = cur - {1'b0, dv_r[i-1].den};
      ge  = cur >= {1'b0, dv_r[i-1].den};
      nxt = dv_r[i-1];
      nxt.rem = ge ? sub[DEN_W-1:0] : cur[DEN_W-1:0];
      nxt.qd  = {dv_r[i-1].qd[QB-2:0], ge};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[i] <= nxt;
      end
    end
  end

  assign res = res_r;

endmodule

// ----- rtl/centripetal_catmull_rom_point.sv -----
// top level of the centripetal catmull-rom point evaluator
// Takes one transaction per cycle and returns one result per cycle while the pipeline is not
// held. A transaction passes 204 register stages from in_data to out_data, a depth set by
// the knot chain (two 32-step square-root pipelines, one digit per stage) and the three
// pyramid levels, each a 44-stage interpolation node with a 38-step divide pipeline. When
// a result waits at the output the pipeline keeps moving as long as its last stage is
// empty; otherwise the whole pipeline holds.
module centripetal_catmull_rom_point (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  ccr_pkg::in_t    in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output ccr_pkg::out_t   out_data
);
  import ccr_pkg::*;

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [NODE_W-1:0] v);
    if ((&v[NODE_W-1:COORD_W-1]) || !(|v[NODE_W-1:COORD_W-1])) begin
      return v[COORD_W-1:0];
    end
    return {v[NODE_W-1], {(COORD_W-1){~v[NODE_W-1]}}};
  endfunction

  logic adv;

  // front stages
  logic                      in_v_r, d_v_r, m_v_r, q_v_r, s_v_r, k_v_r;
  in_t                       in_r, d_pts_r, m_pts_r, q_pts_r;
  logic signed [COORD_W:0]   dx_r [3];
  logic signed [COORD_W:0]   dy_r [3];
  logic [COORD_W-1:0]        ux_r [3];
  logic [COORD_W-1:0]        uy_r [3];
  logic [2:0]                big_m_r, zero_m_r, big_q_r, big_s_r;
  logic [2*COORD_W-1:0]      qx_r [3];
  logic [2*COORD_W-1:0]      qy_r [3];
  logic                      q_degen_r;
  side_t                     s_side_r, k_side_r;
  logic [RAD_W-1:0]          rad_s_r [3];

  logic                      sq_v_r [SQ_STAGES];
  side_t                     sq_side_r [SQ_STAGES];
  sq_lane_t                  sq_r [SQ_STAGES][3];

  logic [KNOT_W-1:0]         k_r [3];
  logic [KNOT_W:0]           kt2_r, kt31_r;
  logic [KNOT_W+POS_W-1:0]   kf_r;
  ctl_t                      ctl_r;
  in_t                       t_pts_r;

  ctl_t                      dly_r [3][LERP_LAT];
  ctl_t                      cl;

  out_t                      out_r;
  logic                      out_valid_r;

  logic signed [COORD_W-1:0] px [4];
  logic signed [COORD_W-1:0] py [4];
  logic signed [COORD_W:0]   dx_nxt [3];
  logic signed [COORD_W:0]   dy_nxt [3];
  logic signed [COORD_W:0]   ndx [3];
  logic signed [COORD_W:0]   ndy [3];
  logic [COORD_W-1:0]        ux_nxt [3];
  logic [COORD_W-1:0]        uy_nxt [3];
  logic [2*COORD_W:0]        ssum [3];
  logic [RAD_W-1:0]          rad_nxt [3];
  in_t                       pts_nxt;
  logic [KNOT_W+POS_W-1:0]   rnd;
  logic [KNOT_W-1:0]         tmt1;
  ctl_t                      ctl_nxt;

  logic signed [NODE_W-1:0]  pa [2][4];
  logic signed [NODE_W-1:0]  ares [2][3];
  logic signed [NODE_W-1:0]  bres [2][2];
  logic signed [NODE_W-1:0]  cres [2];
  logic signed [NUM_W-1:0]   numa [3];
  logic [DEN_W-1:0]          dena [3];
  logic signed [NUM_W-1:0]   numb [2];
  logic [DEN_W-1:0]          denb [2];
  logic signed [NUM_W-1:0]   numc;
  logic [DEN_W-1:0]          denc;
  out_t                      out_nxt;

  assign cl       = dly_r[2][LERP_LAT-1];
  assign adv      = !out_valid_r || out_ready || !cl.valid;
  assign in_ready = adv;

  assign px[0] = in_r.p0_x;
  assign px[1] = in_r.p1_x;
  assign px[2] = in_r.p2_x;
  assign px[3] = in_r.p3_x;
  assign py[0] = in_r.p0_y;
  assign py[1] = in_r.p1_y;
  assign py[2] = in_r.p2_y;
  assign py[3] = in_r.p3_y;

  always_comb begin
    pts_nxt = in_r;
    if (in_r.position_fraction > POS_ONE) begin
      pts_nxt.position_fraction = POS_ONE;
    end
    for (int l = 0; l < 3; l++) begin
      dx_nxt[l]  = (COORD_W+1)'(px[l+1]) - (COORD_W+1)'(px[l]);
      dy_nxt[l]  = (COORD_W+1)'(py[l+1]) - (COORD_W+1)'(py[l]);
      ndx[l]     = -dx_r[l];
      ndy[l]     = -dy_r[l];
      ux_nxt[l]  = dx_r[l][COORD_W] ? ndx[l][COORD_W-1:0] : dx_r[l][COORD_W-1:0];
      uy_nxt[l]  = dy_r[l][COORD_W] ? ndy[l][COORD_W-1:0] : dy_r[l][COORD_W-1:0];
      ssum[l]    = {1'b0, qx_r[l]} + {1'b0, qy_r[l]};
      rad_nxt[l] = big_q_r[l] ? {1'b0, ssum[l][2*COORD_W:2]} : ssum[l][RAD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      d_v_r  <= 1'b0;
      m_v_r  <= 1'b0;
      q_v_r  <= 1'b0;
      s_v_r  <= 1'b0;
      k_v_r  <= 1'b0;
    end else if (adv) begin
      in_v_r <= in_valid;
      d_v_r  <= in_v_r;
      m_v_r  <= d_v_r;
      q_v_r  <= m_v_r;
      s_v_r  <= q_v_r;
      k_v_r  <= sq_v_r[SQ_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_r      <= in_data;
      d_pts_r   <= pts_nxt;
      m_pts_r   <= d_pts_r;
      q_pts_r   <= m_pts_r;
      q_degen_r <= |zero_m_r;
      big_q_r   <= big_m_r;
      s_side_r  <= '{degen: q_degen_r, pts: q_pts_r};
      big_s_r   <= big_q_r;
      for (int l = 0; l < 3; l++) begin
        dx_r[l]     <= dx_nxt[l];
        dy_r[l]     <= dy_nxt[l];
        ux_r[l]     <= ux_nxt[l];
        uy_r[l]     <= uy_nxt[l];
        big_m_r[l]  <= ux_nxt[l][COORD_W-1] | uy_nxt[l][COORD_W-1];
        zero_m_r[l] <= (dx_r[l] == '0) && (dy_r[l] == '0);
        qx_r[l]     <= (2*COORD_W)'(ux_r[l]) * (2*COORD_W)'(ux_r[l]);
        qy_r[l]     <= (2*COORD_W)'(uy_r[l]) * (2*COORD_W)'(uy_r[l]);
        rad_s_r[l]  <= rad_nxt[l];
      end
    end
  end

  // square-root chain: distance first, knot step second
  for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sq
    sq_lane_t          cur [3];
    sq_lane_t          nxt [3];
    logic [SQ_W:0]     gap [3];
    logic              v_in;
    side_t             side_in;
    always_comb begin
      for (int l = 0; l < 3; l++) begin
        if (j == 0) begin
          gap[l] = '0;
          cur[l] = '{rad: rad_s_r[l], big: big_s_r[l], st: '0};
        end else if (j == SQ_W) begin
          gap[l] = sq_r[j-1][l].big ? {sq_r[j-1][l].st.root, 1'b0}
                                    : {1'b0, sq_r[j-1][l].st.root};
          cur[l] = '{rad: {{(RAD_W-SQ_W-1-KNOT_SHIFT){1'b0}}, gap[l], {KNOT_SHIFT{1'b0}}},
                     big: sq_r[j-1][l].big, st: '0};
        end else begin
          gap[l] = '0;
          cur[l] = sq_r[j-1][l];
        end
        nxt[l].st  = sqrt_step(cur[l].st, cur[l].rad[RAD_W-1 -: 2]);
        nxt[l].rad = cur[l].rad << 2;
        nxt[l].big = cur[l].big;
      end
      if (j == 0) begin
        v_in    = s_v_r;
        side_in = s_side_r;
      end else begin
        v_in    = sq_v_r[j-1];
        side_in = sq_side_r[j-1];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[j] <= 1'b0;
      end else if (adv) begin
        sq_v_r[j] <= v_in;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_side_r[j] <= side_in;
        for (int l = 0; l < 3; l++) begin
          sq_r[j][l] <= nxt[l];
        end
      end
    end
  end

  // knots and t
  always_comb begin
    rnd  = kf_r + (KNOT_W+POS_W)'(1 << (POS_BITS - 1));
    tmt1 = rnd[POS_BITS +: KNOT_W];
    ctl_nxt.valid = k_v_r;
    ctl_nxt.degen = k_side_r.degen;
    ctl_nxt.k01   = k_r[0];
    ctl_nxt.k12   = k_r[1];
    ctl_nxt.k23   = k_r[2];
    ctl_nxt.tmt1  = tmt1;
    ctl_nxt.t     = {1'b0, k_r[0]} + {1'b0, tmt1};
    ctl_nxt.t2    = kt2_r;
    ctl_nxt.t31   = kt31_r;
    ctl_nxt.tmt2  = $signed({1'b0, tmt1}) - $signed({1'b0, k_r[1]});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k_side_r <= sq_side_r[SQ_STAGES-1];
      for (int l = 0; l < 3; l++) begin
        k_r[l] <= sq_r[SQ_STAGES-1][l].st.root[KNOT_W-1:0];
      end
      kt2_r  <= {1'b0, sq_r[SQ_STAGES-1][0].st.root[KNOT_W-1:0]}
              + {1'b0, sq_r[SQ_STAGES-1][1].st.root[KNOT_W-1:0]};
      kt31_r <= {1'b0, sq_r[SQ_STAGES-1][1].st.root[KNOT_W-1:0]}
              + {1'b0, sq_r[SQ_STAGES-1][2].st.root[KNOT_W-1:0]};
      kf_r   <= (KNOT_W+POS_W)'(sq_r[SQ_STAGES-1][1].st.root[KNOT_W-1:0])
              * (KNOT_W+POS_W)'(sq_side_r[SQ_STAGES-1].pts.position_fraction);
      t_pts_r <= k_side_r.pts;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_nxt;
    end
  end

  // control follows the pyramid levels
  for (genvar lv = 0; lv < 3; lv++) begin : g_lvl
    for (genvar s = 0; s < LERP_LAT; s++) begin : g_dly
      ctl_t src;
      always_comb begin
        if (s != 0) begin
          src = dly_r[lv][s-1];
        end else if (lv == 0) begin
          src = ctl_r;
        end else begin
          src = dly_r[lv-1][LERP_LAT-1];
        end
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dly_r[lv][s] <= '0;
        end else if (adv) begin
          dly_r[lv][s] <= src;
        end
      end
    end
  end

  always_comb begin
    pa[0][0] = NODE_W'(t_pts_r.p0_x);
    pa[0][1] = NODE_W'(t_pts_r.p1_x);
    pa[0][2] = NODE_W'(t_pts_r.p2_x);
    pa[0][3] = NODE_W'(t_pts_r.p3_x);
    pa[1][0] = NODE_W'(t_pts_r.p0_y);
    pa[1][1] = NODE_W'(t_pts_r.p1_y);
    pa[1][2] = NODE_W'(t_pts_r.p2_y);
    pa[1][3] = NODE_W'(t_pts_r.p3_y);
    numa[0]  = NUM_W'(ctl_r.t);
    numa[1]  = NUM_W'(ctl_r.tmt1);
    numa[2]  = NUM_W'(ctl_r.tmt2);
    dena[0]  = DEN_W'(ctl_r.k01);
    dena[1]  = DEN_W'(ctl_r.k12);
    dena[2]  = DEN_W'(ctl_r.k23);
    numb[0]  = NUM_W'(dly_r[0][LERP_LAT-1].t);
    numb[1]  = NUM_W'(dly_r[0][LERP_LAT-1].tmt1);
    denb[0]  = DEN_W'(dly_r[0][LERP_LAT-1].t2);
    denb[1]  = DEN_W'(dly_r[0][LERP_LAT-1].t31);
    numc     = NUM_W'(dly_r[1][LERP_LAT-1].tmt1);
    denc     = DEN_W'(dly_r[1][LERP_LAT-1].k12);
  end

  for (genvar c = 0; c < 2; c++) begin : g_coord
    for (genvar n = 0; n < 3; n++) begin : g_a
      ccr_lerp u_a (
        .clk (clk),
        .en  (adv),
        .a   (pa[c][n]),
        .b   (pa[c][n+1]),
        .num (numa[n]),
        .den (dena[n]),
        .res (ares[c][n])
      );
    end
    for (genvar n = 0; n < 2; n++) begin : g_b
      ccr_lerp u_b (
        .clk (clk),
        .en  (adv),
        .a   (ares[c][n]),
        .b   (ares[c][n+1]),
        .num (numb[n]),
        .den (denb[n]),
        .res (bres[c][n])
      );
    end
    ccr_lerp u_c (
      .clk (clk),
      .en  (adv),
      .a   (bres[c][0]),
      .b   (bres[c][1]),
      .num (numc),
      .den (denc),
      .res (cres[c])
    );
  end

  // output register
  always_comb begin
    if (cl.degen) begin
      out_nxt = '{curve_x: '0, curve_y: '0, degenerate: 1'b1};
    end else begin
      out_nxt = '{curve_x: sat_coord(cres[0]), curve_y: sat_coord(cres[1]), degenerate: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= cl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/ccr_checker.sv -----
// port-level checks for the catmull-rom point evaluator and their binding
module ccr_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input ccr_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input ccr_pkg::out_t out_data
);
  import ccr_pkg::*;

  logic [COORD_W-1:0] in_x_low;
  assign in_x_low = in_data.p0_x;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while output side is free");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.degenerate) |-> (out_data.curve_x == '0 && out_data.curve_y == '0))
    else $error("degenerate result with nonzero point");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result changed while stalled");

  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> !$isunknown(in_x_low))
    else $error("unknown point accepted");

endmodule

bind centripetal_catmull_rom_point ccr_checker u_ccr_checker (.*);

// ----- tb/sv/centripetal_catmull_rom_point_tb.sv -----
// testbench for the centripetal catmull-rom point evaluator with scoreboard and random traffic
module centripetal_catmull_rom_point_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ccr_pkg::*;

  localparam longint NODE_HI = 64'sd34359738367;
  localparam longint NODE_LO = -64'sd34359738368;
  localparam longint COORD_HI = 64'sd2147483647;
  localparam longint COORD_LO = -64'sd2147483648;
  localparam int LATENCY = 204;
  localparam int N_RANDOM = 1200;
  localparam longint CYCLE_LIMIT = 400000;

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned abs64(input longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint knot_gap(input longint ax, input longint ay,
                                      input longint bx, input longint by);
    longint unsigned ux, uy, qx, qy, gap, s4;
    ux = abs64(bx - ax);
    uy = abs64(by - ay);
    qx = ux * ux;
    qy = uy * uy;
    if (ux < (64'd1 << 31) && uy < (64'd1 << 31)) begin
      gap = root_floor(qx + qy);
    end else begin
      s4 = (qx >> 2) + (qy >> 2) + (((qx & 3) + (qy & 3)) >> 2);
      gap = 2 * root_floor(s4);
    end
    return longint'(root_floor(gap << KNOT_SHIFT));
  endfunction

  function automatic longint blend(input longint a, input longint b, input longint num,
                                   input longint den);
    longint prod, r;
    longint unsigned q;
    if (den <= 0) return a;
    prod = (b - a) * num;
    q = (abs64(prod) + longint'(den) / 2) / longint'(den);
    r = prod < 0 ? -longint'(q) : longint'(q);
    return clamp(a + r, NODE_LO, NODE_HI);
  endfunction

  function automatic out_t curve_point(input in_t d);
    longint px[4], py[4];
    longint k01, k12, k23, t1, t2, t3, t;
    longint a1x, a1y, a2x, a2y, a3x, a3y, b1x, b1y, b2x, b2y;
    longint unsigned f;
    out_t o;
    px[0] = d.p0_x; py[0] = d.p0_y; px[1] = d.p1_x; py[1] = d.p1_y;
    px[2] = d.p2_x; py[2] = d.p2_y; px[3] = d.p3_x; py[3] = d.p3_y;
    f = d.position_fraction;
    if (f > POS_ONE) f = POS_ONE;
    k01 = knot_gap(px[0], py[0], px[1], py[1]);
    k12 = knot_gap(px[1], py[1], px[2], py[2]);
    k23 = knot_gap(px[2], py[2], px[3], py[3]);
    o = '0;
    if (k01 == 0 || k12 == 0 || k23 == 0) begin
      o.degenerate = 1'b1;
      return o;
    end
    t1 = k01;
    t2 = t1 + k12;
    t3 = t2 + k23;
    t = t1 + longint'((longint'(k12) * f + (64'd1 << (POS_BITS - 1))) >> POS_BITS);
    a1x = blend(px[0], px[1], t, k01);
    a1y = blend(py[0], py[1], t, k01);
    a2x = blend(px[1], px[2], t - t1, k12);
    a2y = blend(py[1], py[2], t - t1, k12);
    a3x = blend(px[2], px[3], t - t2, k23);
    a3y = blend(py[2], py[3], t - t2, k23);
    b1x = blend(a1x, a2x, t, t2);
    b1y = blend(a1y, a2y, t, t2);
    b2x = blend(a2x, a3x, t - t1, t3 - t1);
    b2y = blend(a2y, a3y, t - t1, t3 - t1);
    o.curve_x = 32'(clamp(blend(b1x, b2x, t - t1, k12), COORD_LO, COORD_HI));
    o.curve_y = 32'(clamp(blend(b1y, b2y, t - t1, k12), COORD_LO, COORD_HI));
    return o;
  endfunction

  class curve_scoreboard;
    out_t pending[$];
    int errors;

    function void note_transaction(input in_t d);
      pending.insert(pending.size(), curve_point(d));
    endfunction

    function void check_result(input out_t got);
      out_t want;
      if (pending.size() == 0) begin
        $error("unexpected result x=%0d y=%0d", got.curve_x, got.curve_y);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.curve_x !== want.curve_x) begin
        $error("curve_x expected %0d actual %0d", want.curve_x, got.curve_x);
        errors++;
      end
      if (got.curve_y !== want.curve_y) begin
        $error("curve_y expected %0d actual %0d", want.curve_y, got.curve_y);
        errors++;
      end
      if (got.degenerate !== want.degenerate) begin
        $error("degenerate expected %0b actual %0b", want.degenerate, got.degenerate);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  curve_scoreboard sb = new();
  longint cycles = 0;
  bit sending_done = 1'b0;
  bit quiet = 1'b0;

  centripetal_catmull_rom_point dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("centripetal_catmull_rom_point_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  function automatic logic [31:0] rand_coord(input int span);
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2 * span)) - span);
      2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 2 * span)) - span) <<< 8;
    endcase
  endfunction

  function automatic in_t rand_item();
    in_t d;
    int span;
    span = $urandom_range(0, 1) ? 1000 : 3000000;
    d.p0_x = rand_coord(span); d.p0_y = rand_coord(span);
    d.p1_x = rand_coord(span); d.p1_y = rand_coord(span);
    d.p2_x = rand_coord(span); d.p2_y = rand_coord(span);
    d.p3_x = rand_coord(span); d.p3_y = rand_coord(span);
    case ($urandom_range(0, 9))
      0: d.position_fraction = $urandom_range(0, 17'h1ffff);
      1: begin
        d.p1_x = d.p0_x; d.p1_y = d.p0_y;
      end
      2: begin
        d.p2_x = d.p1_x; d.p2_y = d.p1_y;
      end
      3: begin
        d.p3_x = d.p2_x; d.p3_y = d.p2_y;
      end
      default: d.position_fraction = $urandom_range(0, POS_ONE);
    endcase
    if (d.position_fraction === 'x) d.position_fraction = $urandom_range(0, POS_ONE);
    return d;
  endfunction

  task automatic send_item(input in_t d);
    while (!quiet && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_transaction(d);
  endtask

  task automatic directed_items();
    in_t d;
    d.p0_x = 0; d.p0_y = 0;
    d.p1_x = 32'sh0001_0000; d.p1_y = 0;
    d.p2_x = 32'sh0002_0000; d.p2_y = 32'sh0001_0000;
    d.p3_x = 32'sh0003_0000; d.p3_y = 32'sh0003_0000;
    for (int i = 0; i < POS_W; i++) begin
      d.position_fraction = 17'd1 << i;
      send_item(d);
    end
    d.position_fraction = 0; send_item(d);
    d.position_fraction = 17'h1ffff; send_item(d);
    d.p0_x = 32'h8000_0000; d.p0_y = 32'h8000_0000;
    d.p1_x = 32'h7fff_ffff; d.p1_y = 32'h7fff_ffff;
    d.p2_x = 32'h8000_0000; d.p2_y = 32'h7fff_ffff;
    d.p3_x = 32'h7fff_ffff; d.p3_y = 32'h8000_0000;
    d.position_fraction = 17'h08000; send_item(d);
    d.p2_x = 32'h7fff_fff0; d.p2_y = 32'h7fff_fff0; send_item(d);
    d.p1_x = d.p0_x; d.p1_y = d.p0_y; send_item(d);
    d = rand_item(); d.p2_x = d.p1_x; d.p2_y = d.p1_y; send_item(d);
    d = rand_item(); d.p3_x = d.p2_x; d.p3_y = d.p2_y; send_item(d);
    d.p0_x = 0; d.p0_y = 0; d.p1_x = 1; d.p1_y = 0;
    d.p2_x = 32'h7fff_ffff; d.p2_y = 32'h7fff_ffff; d.p3_x = 32'h8000_0000; d.p3_y = 1;
    d.position_fraction = 17'h0ffff; send_item(d);
  endtask

  initial begin
    int i;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_items();
    for (i = 0; i < N_RANDOM; i++) begin
      quiet = (i >= 400 && i < 600);
      send_item(rand_item());
    end
    in_valid <= 1'b0;
    sending_done = 1'b1;
  end

  initial begin
    int n;
    n = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      n++;
      if (n == 300) begin
        out_ready <= 1'b0;
        repeat (500) @(posedge clk);
      end
      if (quiet) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 99) >= 33);
    end
  end

  initial begin
    wait (sending_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 50) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("centripetal_catmull_rom_point_tb: PASS");
    else
      $display("centripetal_catmull_rom_point_tb: FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ccr_pkg.sv
rtl/ccr_lerp.sv
rtl/centripetal_catmull_rom_point.sv
rtl/ccr_checker.sv
tb/sv/centripetal_catmull_rom_point_tb.sv
